[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules of the cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising clock edge while reset is low.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checks that an expression holds at every rising clock edge while reset is low.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

[sv/lruc_pkg.sv]
// Package of types and constants for the LRU key-value cache.
package lruc_pkg;

   localparam int ENTRIES = 16;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   typedef enum logic {
      FUNC_GET = 1'b0,
      FUNC_PUT = 1'b1
   } func_type;

   typedef logic [DATA_W-1:0]  word_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [CAP_W-1:0]   cap_type;
   typedef logic [ENTRIES-1:0] entry_vec_type;

   typedef word_type word_array_type [ENTRIES];
   typedef rank_type rank_array_type [ENTRIES];

   typedef struct packed {
      func_type                 func;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic          hit;
      entry_vec_type hit_onehot;
      rank_type      hit_rank;
      word_type      hit_value;
      entry_vec_type victim_onehot;
      entry_vec_type free_onehot;
      logic          full;
   } lookup_type;

endpackage

[sv/lruc_lookup.sv]
// Parallel tag compare, victim and free slot selection for the cache.
module lruc_lookup
   import lruc_pkg::*;
(
   input  entry_vec_type  entry_valid,
   input  word_array_type entry_key,
   input  word_array_type entry_value,
   input  rank_array_type entry_rank,
   input  count_type      occupied,
   input  count_type      eff_capacity,
   input  word_type       key,
   output lookup_type     lookup
);

   entry_vec_type match;
   entry_vec_type hit_oh;
   entry_vec_type free_vec;
   entry_vec_type victim_vec;
   rank_type      oldest_rank;

   // With ranks a permutation of 0 .. occupied-1, the oldest entry is unique.
   assign oldest_rank = RANK_W'(occupied - CNT_W'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]      = entry_valid[i] && (entry_key[i] == key);
         free_vec[i]   = !entry_valid[i];
         victim_vec[i] = entry_valid[i] && (entry_rank[i] == oldest_rank);
      end
   end

   assign hit_oh = match & (~match + ENTRIES'(1));

   always_comb begin
      lookup               = '0;
      lookup.hit           = |match;
      lookup.hit_onehot    = hit_oh;
      lookup.victim_onehot = victim_vec;
      lookup.free_onehot   = free_vec & (~free_vec + ENTRIES'(1));
      lookup.full          = occupied >= eff_capacity;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_oh[i]) begin
            lookup.hit_rank  = lookup.hit_rank | entry_rank[i];
            lookup.hit_value = lookup.hit_value | entry_value[i];
         end
      end
   end

endmodule

[sv/lruc_store.sv]
// Entry store of the cache: tags, values, recency ranks and occupancy.
module lruc_store
   import lruc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      update_en,
   input  req_type   req,
   input  count_type eff_capacity,
   output rsp_type   rsp
);

`include "assert_macros.svh"

   entry_vec_type  valid_ff, valid_in;
   word_array_type key_ff, key_in;
   word_array_type value_ff, value_in;
   rank_array_type rank_ff, rank_in;
   count_type      count_ff, count_in;
   lookup_type     lk;
   entry_vec_type  slot;

   lruc_lookup u_lookup (
      .entry_valid  (valid_ff),
      .entry_key    (key_ff),
      .entry_value  (value_ff),
      .entry_rank   (rank_ff),
      .occupied     (count_ff),
      .eff_capacity (eff_capacity),
      .key          (word_type'(req.key)),
      .lookup       (lk)
   );

   assign slot = lk.full ? lk.victim_onehot : lk.free_onehot;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      if (update_en) begin
         if (lk.hit) begin
            // Promote the hit entry; entries younger than it age by one.
            for (int i = 0; i < ENTRIES; i++) begin
               if (lk.hit_onehot[i]) begin
                  rank_in[i] = '0;
                  if (req.func == FUNC_PUT) begin
                     value_in[i] = word_type'(req.write_value);
                  end
               end else if (valid_ff[i] && (rank_ff[i] < lk.hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end else if (req.func == FUNC_PUT) begin
            // Insert into the victim or the first free slot; all others age.
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot[i]) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = word_type'(req.key);
                  value_in[i] = word_type'(req.write_value);
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            if (!lk.full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp.found = lk.hit;
      if (req.func == FUNC_PUT) begin
         rsp.read_value = '0;
      end else if (lk.hit) begin
         rsp.read_value = lk.hit_value;
      end else begin
         rsp.read_value = MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   `ASSERT_ALWAYS(a_count_matches_valid, clock, reset, $countones(valid_ff) == int'(count_ff))
   `ASSERT_ALWAYS(a_count_in_range, clock, reset, int'(count_ff) <= ENTRIES)
   `ASSERT_PROP(a_put_miss_fills, clock, reset, (update_en && !lk.hit && req.func == FUNC_PUT) |-> $onehot(slot))

endmodule

[sv/lru_key_value_cache_unit.sv]
// Top level of the fully associative key-value cache with LRU replacement.
//
//   channel  direction  payload      handshake
//   req_     in         req_type     req_valid / req_ready
//   rsp_     out        rsp_type     rsp_valid / rsp_ready
//   csr_     in         capacity     csr_valid / csr_ready (always ready)
//
// One request transfer per cycle is sustained while responses are taken. A
// request transfer loads the request register; the tag compare and rank
// update run while the request sits there, and they load the response
// register once it is free or being emptied, which offers the response.
// Reset is synchronous and clears the valid bits, the occupancy count and the
// handshake state, and sets the capacity to sixteen; no clearing pass is run.
// When the response register is full and not taken, the request register holds
// its item and req_ready falls in the same cycle.
module lru_key_value_cache_unit
   import lruc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  cap_type csr_data
);

`include "assert_macros.svh"

   // Request register and response register with their valid flags.
   logic      req_valid_ff, req_valid_in;
   req_type   req_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   cap_type   capacity_ff, capacity_in;
   count_type eff_capacity;
   rsp_type   store_rsp;
   logic      advance;

   // The stored request is processed when the response register is free or is
   // being emptied in this same cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign capacity_in  = csr_valid ? csr_data : capacity_ff;

   // A capacity of zero behaves as one, and anything above the store size is
   // saturated to the number of entries.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_capacity = CNT_W'(1);
      end else if (int'(capacity_ff) > ENTRIES) begin
         eff_capacity = CNT_W'(ENTRIES);
      end else begin
         eff_capacity = CNT_W'(capacity_ff);
      end
   end

   lruc_store u_store (
      .clock        (clock),
      .reset        (reset),
      .update_en    (advance),
      .req          (req_ff),
      .eff_capacity (eff_capacity),
      .rsp          (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   // Payload registers load on a transfer and otherwise hold.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= store_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_PROP(a_advance_loads_rsp, clock, reset, advance |=> rsp_valid_ff)
   `ASSERT_PROP(a_stall_holds_req, clock, reset, (req_valid_ff && rsp_valid_ff && !rsp_ready) |=> (req_valid_ff && $stable(req_ff)))
   `ASSERT_PROP(a_csr_write_lands, clock, reset, (csr_valid && !reset) |=> (capacity_ff == $past(csr_data)))

endmodule

[tb/tb_lru_key_value_cache_unit.sv]
// Self-checking testbench for the LRU key-value cache unit with a cycle-free cache image.
module tb_lru_key_value_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lruc_pkg::*;

   // The response latency plus a margin, waited out before the capacity
   // register is touched or the run is closed.
   localparam int RESPONSE_LATENCY = 2;
   localparam int SETTLE_CYCLES    = RESPONSE_LATENCY + 4;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int POOL_DEPTH       = 2 * ENTRIES;
   localparam int PHASE_ITEMS      = 190;
   localparam int HOLD_CYCLES      = 90;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   cap_type csr_data;

   // Image of the cache contents, updated as each request transfer is taken.
   logic     line_valid [ENTRIES];
   word_type line_key   [ENTRIES];
   word_type line_value [ENTRIES];
   rank_type line_age   [ENTRIES];
   int       lines_used;
   cap_type  capacity_setting;

   // Responses predicted but not yet seen, oldest first.
   rsp_type  pending_rsp [$];

   int       error_count;
   bit       gaps_on;
   int       hold_request;
   int       cycle_count;

   lru_key_value_cache_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // A capacity of zero behaves as one entry, and anything above the array
   // size is clipped to the array size.
   function automatic int usable_entries(input cap_type setting);
      if (setting == 0) begin
         return 1;
      end
      if (setting > ENTRIES) begin
         return ENTRIES;
      end
      return int'(setting);
   endfunction

   // Applies one request to the cache image and returns the response it
   // should produce. Rank 0 is the most recent entry.
   function automatic rsp_type lookup_and_update(input req_type item);
      rsp_type  result;
      int       hit_slot;
      int       slot;
      rank_type hit_age;
      rank_type oldest_age;
      hit_slot   = -1;
      slot       = -1;
      hit_age    = '0;
      oldest_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_slot < 0 && line_valid[i] && line_key[i] == word_type'(item.key)) begin
            hit_slot = i;
         end
      end

      if (hit_slot >= 0) begin
         result.found = 1'b1;
         if (item.func == FUNC_GET) begin
            result.read_value = line_value[hit_slot];
         end else begin
            result.read_value = '0;
            line_value[hit_slot] = item.write_value;
         end
         // Everything younger than the hit entry ages by one.
         hit_age = line_age[hit_slot];
         for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && i != hit_slot && line_age[i] < hit_age) begin
               line_age[i] = line_age[i] + 1'b1;
            end
         end
         line_age[hit_slot] = '0;
         return result;
      end

      result.found = 1'b0;
      if (item.func == FUNC_GET) begin
         result.read_value = MISS_VALUE;
         return result;
      end
      result.read_value = '0;

      // A put miss on a full store evicts the oldest entry and reuses its
      // slot, leaving the occupancy as it was, even if capacity was lowered.
      if (lines_used >= usable_entries(capacity_setting)) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && (slot < 0 || line_age[i] > oldest_age)) begin
               slot       = i;
               oldest_age = line_age[i];
            end
         end
         if (slot >= 0) begin
            line_valid[slot] = 1'b0;
         end else begin
            lines_used = 0;
         end
      end
      if (slot < 0) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !line_valid[i]) begin
               slot = i;
            end
         end
         lines_used++;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (line_valid[i]) begin
            line_age[i] = line_age[i] + 1'b1;
         end
      end
      line_valid[slot] = 1'b1;
      line_key[slot]   = item.key;
      line_value[slot] = item.write_value;
      line_age[slot]   = '0;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input word_type want, input word_type got);
      $display("%0t ns: mismatch on %s: expected %08h, got %08h", $time, what, want, got);
      error_count++;
   endtask

   // Offers one request after a random gap and holds it until the transfer.
   // Valid is only lowered when a gap is drawn, so back-to-back requests
   // keep it high across the boundary.
   task automatic send_request(input func_type op, input word_type key, input word_type value);
      req_type item;
      int      gap;
      item.func        = op;
      item.key         = key;
      item.write_value = value;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(lookup_and_update(item));
   endtask

   // Stops offering requests and waits until every predicted response has
   // arrived and the pipeline has had time to empty.
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input cap_type value);
      wait_for_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A random word, with the extremes of the signed range turning up often.
   function automatic word_type random_word();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Extreme keys and values, a miss on an empty store, hits, an update and a miss on an absent key.
   task automatic test_field_extremes();
      write_capacity(cap_type'(ENTRIES));
      send_request(FUNC_GET, 32'h0000_0000, 32'h1111_1111);
      send_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
      send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
   endtask

   // Replacement order with one and two entries; a capacity of zero must
   // behave as a single entry.
   task automatic test_eviction_order();
      write_capacity(cap_type'(0));
      send_request(FUNC_PUT, 32'd5, 32'hAAAA_0005);
      send_request(FUNC_PUT, 32'd6, 32'hAAAA_0006);
      send_request(FUNC_GET, 32'd5, 32'h0000_0000);
      send_request(FUNC_GET, 32'd6, 32'h0000_0000);
      write_capacity(cap_type'(2));
      send_request(FUNC_PUT, 32'd5, 32'hBBBB_0005);
      send_request(FUNC_GET, 32'd6, 32'h0000_0000);
      send_request(FUNC_PUT, 32'd7, 32'hBBBB_0007);
      send_request(FUNC_GET, 32'd5, 32'h0000_0000);
      send_request(FUNC_GET, 32'd7, 32'h0000_0000);
   endtask

   // An oversized capacity saturates; lowering it while the store is
   // fuller than the new limit must keep the entries and evict one per put miss.
   task automatic test_capacity_lowered();
      write_capacity(cap_type'(31));
      for (int i = 0; i < 4; i++) begin
         send_request(FUNC_PUT, word_type'(100 + i), word_type'(32'hC000_0000 + i));
      end
      write_capacity(cap_type'(2));
      send_request(FUNC_PUT, 32'd104, 32'hC000_0004);
      send_request(FUNC_GET, 32'd6, 32'h0000_0000);
      send_request(FUNC_GET, 32'd103, 32'h0000_0000);
   endtask

   // Phases of random traffic, each under its own capacity. Keys come mostly
   // from a pool a little larger than the capacity, so hits, updates and
   // evictions all happen often; some keys are fully random misses.
   task automatic test_random_traffic();
      cap_type  plan [8];
      word_type pool [POOL_DEPTH];
      int       pool_size;
      func_type op;
      word_type key;
      plan[0] = cap_type'(ENTRIES);
      plan[1] = cap_type'(31);
      plan[2] = cap_type'(1);
      plan[3] = cap_type'(0);
      plan[4] = cap_type'(7);
      plan[5] = cap_type'(17);
      plan[6] = cap_type'($urandom_range(1, ENTRIES));
      plan[7] = cap_type'($urandom_range(0, 31));
      foreach (plan[phase]) begin
         write_capacity(plan[phase]);
         gaps_on   = (phase % 3) != 2;
         pool_size = usable_entries(plan[phase]) + 1
                     + $urandom_range(0, usable_entries(plan[phase]) + 1);
         if (pool_size > POOL_DEPTH) begin
            pool_size = POOL_DEPTH;
         end
         for (int i = 0; i < POOL_DEPTH; i++) begin
            pool[i] = random_word();
         end
         repeat (PHASE_ITEMS) begin
            op  = $urandom_range(0, 1) ? FUNC_PUT : FUNC_GET;
            key = ($urandom_range(0, 15) == 0) ? word_type'($urandom)
                                               : pool[$urandom_range(0, pool_size - 1)];
            send_request(op, key, random_word());
         end
      end
      gaps_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch after its next transfer while
   // requests keep coming at full rate, so the unit fills and drops req_ready.
   task automatic test_back_pressure();
      wait_for_idle();
      gaps_on      = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (48) begin
         send_request($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET,
                      word_type'($urandom_range(0, 9)), random_word());
      end
      gaps_on = 1'b1;
   endtask

   // Response side: a random stall before each transfer, or the long hold
   // when one has been requested. The hold is counted here, cycle by cycle.
   initial begin : rsp_side
      int stall;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = gaps_on ? $urandom_range(0, 5) : 0;
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Every response transfer is compared with the oldest prediction.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response transfer with no request outstanding",
                            '0, rsp_data.read_value);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found) begin
               report_mismatch("found", word_type'(want.found), word_type'(rsp_data.found));
            end
            if (rsp_data.read_value !== want.read_value) begin
               report_mismatch("read_value", want.read_value, rsp_data.read_value);
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_lru_key_value_cache_unit: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      error_count  = 0;
      gaps_on      = 1'b1;
      hold_request = 0;
      lines_used   = 0;
      capacity_setting = CAP_RESET;
      foreach (line_valid[i]) begin
         line_valid[i] = 1'b0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_eviction_order();
      test_capacity_lowered();
      test_random_traffic();
      test_back_pressure();

      wait_for_idle();
      if (error_count == 0) begin
         $display("tb_lru_key_value_cache_unit: PASS");
      end else begin
         $display("tb_lru_key_value_cache_unit: FAIL");
      end
      $finish;
   end

endmodule
